// File: src/serial_bus_attention_decoder_macros.svh
`ifndef SERIAL_BUS_ATTENTION_DECODER_MACROS_SVH
`define SERIAL_BUS_ATTENTION_DECODER_MACROS_SVH

// same-cycle implication, off during reset
`define SBAD_ASSERT_NOW(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define SBAD_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`endif

// File: src/sbad_pkg.sv
package sbad_pkg;

  localparam int MaxNameLength = 64;

  localparam logic [1:0] OP_ATN_ON  = 2'd0;
  localparam logic [1:0] OP_BYTE    = 2'd1;
  localparam logic [1:0] OP_ATN_OFF = 2'd2;

  localparam logic [2:0] ST_PENDING = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_LISTEN  = 3'd2;
  localparam logic [2:0] ST_TALK    = 3'd3;
  localparam logic [2:0] ST_COMMAND = 3'd4;
  localparam logic [2:0] ST_ERROR   = 3'd5;
  localparam logic [2:0] ST_IGNORE  = 3'd6;

  localparam logic [7:0] PRI_LISTEN   = 8'h20;
  localparam logic [7:0] PRI_TALK     = 8'h40;
  localparam logic [7:0] BUS_UNLISTEN = 8'h3F;
  localparam logic [7:0] BUS_UNTALK   = 8'h5F;
  localparam logic [7:0] CMD_DATA     = 8'h60;
  localparam logic [7:0] CMD_CLOSE    = 8'hE0;
  localparam logic [7:0] CMD_OPEN     = 8'hF0;
  localparam logic [7:0] CMD_MASK     = 8'hF0;
  localparam logic [7:0] CHAN_MASK    = 8'h0F;
  localparam logic [3:0] CHAN_CMD     = 4'd15;
  localparam logic [7:0] CHAR_CR      = 8'h0D;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic       rx_error;
  } item_t;

  typedef struct packed {
    logic [2:0] status;
    logic       release_lines;
    logic [7:0] device_number;
    logic [7:0] command_nibble;
    logic [3:0] channel_number;
    logic       char_valid;
    logic [7:0] char_out;
    logic [6:0] name_length;
  } result_t;

endpackage

// File: src/sbad_core.sv
module sbad_core #(
  parameter int MAX_NAME_LENGTH = sbad_pkg::MaxNameLength
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  sbad_pkg::item_t   item,
  input  logic [31:0]       enabled_devices,
  output sbad_pkg::result_t res
);

  localparam int LEN_W = $clog2(MAX_NAME_LENGTH + 1);
  localparam int CMP_W = (LEN_W > 7) ? LEN_W : 8;

  localparam logic [2:0] PH_IDLE        = 3'd0;
  localparam logic [2:0] PH_PRIMARY     = 3'd1;
  localparam logic [2:0] PH_SECONDARY   = 3'd2;
  localparam logic [2:0] PH_LISTEN_NAME = 3'd3;
  localparam logic [2:0] PH_TALK_NAME   = 3'd4;
  localparam logic [2:0] PH_RELEASED    = 3'd5;
  localparam logic [2:0] PH_HOLD        = 3'd6;

  localparam logic [1:0] ROLE_NONE   = 2'd0;
  localparam logic [1:0] ROLE_LISTEN = 2'd1;
  localparam logic [1:0] ROLE_TALK   = 2'd2;

  logic [2:0]       phase, phase_next;
  logic [1:0]       role, role_next;
  logic [7:0]       device_reg, device_reg_next;
  logic [7:0]       command_reg, command_reg_next;
  logic [3:0]       channel_reg, channel_reg_next;
  logic [LEN_W-1:0] length_count, length_count_next;
  logic             error_seen, error_seen_next;

  logic [2:0]       status;
  logic             rel;
  logic             cv;
  logic [7:0]       ch;
  logic [7:0]       dev;
  logic [1:0]       dev_role;
  logic             dev_on;
  logic [7:0]       cmd;
  logic [3:0]       chan;
  logic [CMP_W-1:0] len_ext;

  // primary byte decode
  always_comb begin
    if ((item.data_byte & sbad_pkg::PRI_LISTEN) != 8'd0) begin
      dev_role = ROLE_LISTEN;
      dev      = item.data_byte ^ sbad_pkg::PRI_LISTEN;
    end else begin
      dev_role = ((item.data_byte & sbad_pkg::PRI_TALK) != 8'd0) ? ROLE_TALK : ROLE_NONE;
      dev      = item.data_byte ^ sbad_pkg::PRI_TALK;
    end
    dev_on = (dev[7:5] == 3'd0) && enabled_devices[dev[4:0]];
    cmd    = item.data_byte & sbad_pkg::CMD_MASK;
    chan   = item.data_byte[3:0] & sbad_pkg::CHAN_MASK[3:0];
  end

  always_comb begin
    phase_next        = phase;
    role_next         = role;
    device_reg_next   = device_reg;
    command_reg_next  = command_reg;
    channel_reg_next  = channel_reg;
    length_count_next = length_count;
    error_seen_next   = error_seen;
    status            = sbad_pkg::ST_IDLE;
    rel               = 1'b0;
    cv                = 1'b0;
    ch                = 8'd0;

    if (item.opcode == sbad_pkg::OP_ATN_ON) begin
      status = sbad_pkg::ST_PENDING;
      if (phase != PH_LISTEN_NAME && phase != PH_TALK_NAME) begin
        phase_next        = PH_PRIMARY;
        role_next         = ROLE_NONE;
        length_count_next = '0;
        error_seen_next   = 1'b0;
      end
    end else if (item.opcode == sbad_pkg::OP_ATN_OFF) begin
      if (phase == PH_LISTEN_NAME) begin
        status = sbad_pkg::ST_PENDING;
      end else if (phase == PH_TALK_NAME) begin
        status     = sbad_pkg::ST_TALK;
        phase_next = PH_IDLE;
      end else begin
        status     = sbad_pkg::ST_IDLE;
        phase_next = PH_IDLE;
      end
    end else if (item.opcode == sbad_pkg::OP_BYTE) begin
      unique case (phase)
        PH_PRIMARY: begin
          if (item.rx_error) begin
            error_seen_next = 1'b1;
            status          = sbad_pkg::ST_ERROR;
            phase_next      = PH_HOLD;
          end else if (item.data_byte == sbad_pkg::BUS_UNLISTEN ||
                       item.data_byte == sbad_pkg::BUS_UNTALK) begin
            role_next  = ROLE_NONE;
            status     = sbad_pkg::ST_IDLE;
            rel        = 1'b1;
            phase_next = PH_RELEASED;
          end else begin
            device_reg_next = dev;
            role_next       = dev_role;
            if (dev_on) begin
              status     = sbad_pkg::ST_PENDING;
              phase_next = PH_SECONDARY;
            end else begin
              status     = sbad_pkg::ST_IGNORE;
              rel        = 1'b1;
              phase_next = PH_RELEASED;
            end
          end
        end
        PH_SECONDARY: begin
          if (item.rx_error) begin
            error_seen_next = 1'b1;
            status          = sbad_pkg::ST_ERROR;
            phase_next      = PH_HOLD;
          end else begin
            command_reg_next = cmd;
            channel_reg_next = chan;
            if (role == ROLE_LISTEN) begin
              if (cmd == sbad_pkg::CMD_DATA && chan != sbad_pkg::CHAN_CMD) begin
                status     = sbad_pkg::ST_LISTEN;
                phase_next = PH_HOLD;
              end else if (cmd == sbad_pkg::CMD_DATA || cmd == sbad_pkg::CMD_OPEN) begin
                status            = sbad_pkg::ST_PENDING;
                length_count_next = '0;
                phase_next        = PH_LISTEN_NAME;
              end else if (cmd == sbad_pkg::CMD_CLOSE) begin
                status     = sbad_pkg::ST_COMMAND;
                phase_next = PH_HOLD;
              end else begin
                status     = sbad_pkg::ST_IDLE;
                phase_next = PH_HOLD;
              end
            end else if (role == ROLE_TALK) begin
              status            = sbad_pkg::ST_PENDING;
              length_count_next = '0;
              phase_next        = PH_TALK_NAME;
            end else begin
              status     = sbad_pkg::ST_IDLE;
              phase_next = PH_HOLD;
            end
          end
        end
        PH_LISTEN_NAME, PH_TALK_NAME: begin
          if (item.rx_error) begin
            error_seen_next = 1'b1;
            status          = sbad_pkg::ST_ERROR;
            rel             = 1'b1;
            phase_next      = PH_RELEASED;
          end else if (phase == PH_LISTEN_NAME &&
                       item.data_byte == sbad_pkg::BUS_UNLISTEN) begin
            status     = (length_count != '0) ? sbad_pkg::ST_COMMAND : sbad_pkg::ST_IDLE;
            phase_next = PH_HOLD;
          end else if (length_count >= LEN_W'(MAX_NAME_LENGTH)) begin
            status     = sbad_pkg::ST_ERROR;
            phase_next = PH_HOLD;
          end else begin
            status = sbad_pkg::ST_PENDING;
            if (phase == PH_TALK_NAME || item.data_byte != sbad_pkg::CHAR_CR) begin
              cv                = 1'b1;
              ch                = item.data_byte;
              length_count_next = length_count + LEN_W'(1);
            end
          end
        end
        PH_RELEASED, PH_HOLD: begin
          status = error_seen ? sbad_pkg::ST_ERROR : sbad_pkg::ST_IGNORE;
        end
        default: begin
          status = sbad_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // length shown saturated at 127
  assign len_ext = CMP_W'(length_count_next);

  always_comb begin
    res.status         = status;
    res.release_lines  = rel;
    res.device_number  = device_reg_next;
    res.command_nibble = command_reg_next;
    res.channel_number = channel_reg_next;
    res.char_valid     = cv;
    res.char_out       = ch;
    res.name_length    = (len_ext > CMP_W'(127)) ? 7'd127 : len_ext[6:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      role         <= ROLE_NONE;
      device_reg   <= 8'd0;
      command_reg  <= 8'd0;
      channel_reg  <= 4'd0;
      length_count <= '0;
      error_seen   <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      role         <= role_next;
      device_reg   <= device_reg_next;
      command_reg  <= command_reg_next;
      channel_reg  <= channel_reg_next;
      length_count <= length_count_next;
      error_seen   <= error_seen_next;
    end
  end

endmodule

// File: src/serial_bus_attention_decoder.sv
// each accepted item's result is registered in the output register, or in the skid entry while the output stalls
// throughput: one item per cycle while item_stall is low; the decode state updates in one pass
// a two-entry output stage takes one more item while a result waits
// reset: synchronous, active high; clears decode state, device mask and
// all valid flags
module serial_bus_attention_decoder #(
  parameter int MAX_NAME_LENGTH = sbad_pkg::MaxNameLength
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       cfg_data,
  input  logic              item_valid,
  output logic              item_stall,
  input  sbad_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output sbad_pkg::result_t result
);

  `include "serial_bus_attention_decoder_macros.svh"

  logic              accept;
  logic              out_take;
  logic [31:0]       enabled_devices;
  logic              skid_valid;
  sbad_pkg::result_t skid;
  sbad_pkg::result_t core_res;
  logic              rel_ok;

  assign cfg_ready  = 1'b1;
  assign item_stall = skid_valid;
  assign accept     = item_valid && !item_stall;
  assign out_take   = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled_devices <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      enabled_devices <= cfg_data;
    end
  end

  sbad_core #(
    .MAX_NAME_LENGTH(MAX_NAME_LENGTH)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .item           (item),
    .enabled_devices(enabled_devices),
    .res            (core_res)
  );

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (out_take) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      if (skid_valid) begin
        result <= skid;
      end else if (accept) begin
        result <= core_res;
      end
    end else if (accept) begin
      skid <= core_res;
    end
  end

  assign rel_ok = result.status == sbad_pkg::ST_IDLE ||
                  result.status == sbad_pkg::ST_IGNORE ||
                  result.status == sbad_pkg::ST_ERROR;

  `SBAD_ASSERT_NOW(a_skid_needs_out, clk, rst, skid_valid, result_valid)
  `SBAD_ASSERT_NOW(a_char_zero, clk, rst, result_valid && !result.char_valid, ~|result.char_out)
  `SBAD_ASSERT_NOW(a_release_status, clk, rst, result_valid && result.release_lines, rel_ok)
  `SBAD_ASSERT_NEXT(a_accept_valid, clk, rst, accept, result_valid)

endmodule
